// ===== sv/acs_pkg.sv =====
// Shared types and constants for the Aho-Corasick longest-match scanner.
// Command codes, sequencer states, word field positions and table control.
// No dependencies.
package acs_pkg;

    // Command carried in s_tuser
    typedef enum logic [1:0] {
        CMD_LOAD_EDGE = 2'd0,
        CMD_LOAD_NODE = 2'd1,
        CMD_SCAN      = 2'd2,
        CMD_END       = 2'd3
    } cmd_t;

    // Scan sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDGE,
        ST_FAIL,
        ST_WORD
    } state_t;

    // Fixed field widths
    localparam int CMD_W    = 2;
    localparam int FNODE_W  = 6;
    localparam int BYTE_W   = 8;
    localparam int DEPTH_W  = 6;
    localparam int KIND_W   = 3;
    localparam int START_W  = 32;

    // Input word layout (s_tdata), lowest bit first
    localparam int S_NODE_LSB   = 0;
    localparam int S_BYTE_LSB   = 6;
    localparam int S_TARGET_LSB = 14;
    localparam int S_DEPTH_LSB  = 20;
    localparam int S_WORD_LSB   = 26;
    localparam int S_KIND_LSB   = 27;
    localparam int S_TDATA_W    = 32;

    // Output word layout (m_tdata), lowest bit first
    localparam int M_START_LSB  = 0;
    localparam int M_LEN_LSB    = 32;
    localparam int M_KIND_LSB   = 38;
    localparam int M_USED_W     = 41;
    localparam int M_TDATA_W    = 48;

    // Per-node attributes held next to the fail link
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               is_word;
        logic [KIND_W-1:0]  kind;
    } node_attr_t;

    // Table port strobes from the sequencer
    typedef struct packed {
        logic edge_we;
        logic edge_re;
        logic info_we;
        logic info_re;
    } tbl_ctrl_t;

endpackage

// ===== sv/acs_tables.sv =====
// Automaton storage: the edge memory (node, byte -> child) and the node
// info memory (fail link plus depth, word flag, kind). Uses acs_pkg.
// One write and one registered read port on each memory.
module acs_tables
    import acs_pkg::*;
#(
    parameter int NODE_COUNT = 64
)
(
    input  logic                              clk,
    input  tbl_ctrl_t                         ctrl,
    input  logic [$clog2(NODE_COUNT)+7:0]     edge_waddr,
    input  logic [$clog2(NODE_COUNT)-1:0]     edge_wdata,
    input  logic [$clog2(NODE_COUNT)+7:0]     edge_raddr,
    output logic [$clog2(NODE_COUNT)-1:0]     edge_rdata,
    input  logic [$clog2(NODE_COUNT)-1:0]     info_waddr,
    input  logic [$clog2(NODE_COUNT)-1:0]     info_wfail,
    input  node_attr_t                        info_wattr,
    input  logic [$clog2(NODE_COUNT)-1:0]     info_raddr,
    output logic [$clog2(NODE_COUNT)-1:0]     info_rfail,
    output node_attr_t                        info_rattr
);

    localparam int NB         = $clog2(NODE_COUNT);
    localparam int EDGE_DEPTH = NODE_COUNT * 256;
    localparam int INFO_W     = NB + $bits(node_attr_t);

    logic [NB-1:0]     edge_mem [EDGE_DEPTH];
    logic [INFO_W-1:0] info_mem [NODE_COUNT];
    logic [NB-1:0]     edge_rdata_reg;
    logic [INFO_W-1:0] info_rdata_reg;

    // Edge memory: write port and registered read port
    always_ff @(posedge clk)
    begin
        if (ctrl.edge_we)
        begin
            edge_mem[edge_waddr] <= edge_wdata;
        end
        if (ctrl.edge_re)
        begin
            edge_rdata_reg <= edge_mem[edge_raddr];
        end
    end

    // Node info memory: write port and registered read port
    always_ff @(posedge clk)
    begin
        if (ctrl.info_we)
        begin
            info_mem[info_waddr] <= {info_wfail, info_wattr};
        end
        if (ctrl.info_re)
        begin
            info_rdata_reg <= info_mem[info_raddr];
        end
    end

    assign edge_rdata = edge_rdata_reg;
    assign info_rfail = info_rdata_reg[INFO_W-1 -: NB];
    assign info_rattr = node_attr_t'(info_rdata_reg[$bits(node_attr_t)-1:0]);

endmodule

// ===== sv/aho_corasick_longest_match_scanner.sv =====
// Top level of the Aho-Corasick longest-match scanner: command decode,
// scan sequencer, pending match and output register. Uses acs_pkg and
// acs_tables.
//
// Software loads the automaton with load-edge and load-node words, then
// streams text one byte per scan word and closes it with an end word. After
// reset the block sweeps all NODE_COUNT*256 entries (16384 at the default)
// of the edge memory to zero, one entry per cycle, and holds s_tready low
// meanwhile. A scan byte does one edge lookup and, when it succeeds, one
// child attribute read; each fail link adds one node info read and one more
// edge lookup, and a last lookup that finds no edge skips the child
// attribute read. Each attempt is one registered read of the edge memory
// and each step (fail link or child attributes) one registered read of the
// node info memory, all issued by one sequencer, so a byte is done before the
// next is taken. A match waiting in the output register holds off input only
// while the scanner also keeps a pending match that the next word may need to
// emit.
module aho_corasick_longest_match_scanner
    import acs_pkg::*;
#(
    parameter int NODE_COUNT    = 64,
    parameter int POSITION_BITS = 32,
    parameter int MAX_DEPTH     = 63
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // s_tdata fields, low bit up: node_index[6], byte_value[8], target_node[6],
    // node_depth[6], node_is_word[1], node_kind[3], zero pad[2]
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser fields: command[2]
    input  logic [CMD_W-1:0]     s_tuser,
    // m_tdata fields, low bit up: match_start[32], match_length[6],
    // match_kind[3], zero pad[7]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int NB        = $clog2(NODE_COUNT);
    localparam int EAW       = NB + BYTE_W;
    localparam int EDGE_LAST = NODE_COUNT * 256 - 1;
    localparam int SW        = (POSITION_BITS + 1 > START_W) ? POSITION_BITS + 1 : START_W + 1;

    state_t                   state_reg, state_next;
    logic [EAW-1:0]           clr_addr_reg, clr_addr_next;
    logic [NB-1:0]            cur_reg, cur_next;
    logic [BYTE_W-1:0]        byte_reg, byte_next;
    logic [1:0]               try_reg, try_next;
    logic                     emitted_reg, emitted_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [POSITION_BITS-1:0] pend_end_reg, pend_end_next;
    logic [DEPTH_W-1:0]       pend_len_reg, pend_len_next;
    logic [KIND_W-1:0]        pend_kind_reg, pend_kind_next;
    logic                     out_valid_reg, out_valid_next;
    logic [START_W-1:0]       out_start_reg, out_start_next;
    logic [DEPTH_W-1:0]       out_len_reg, out_len_next;
    logic [KIND_W-1:0]        out_kind_reg, out_kind_next;

    cmd_t               cmd;
    logic [FNODE_W-1:0] in_node;
    logic [BYTE_W-1:0]  in_byte;
    logic [FNODE_W-1:0] in_target;
    node_attr_t         in_attr;
    logic               node_ok;
    logic [NB-1:0]      node_idx;
    logic [NB-1:0]      tgt_clean;
    logic               accept;
    logic               out_free;

    tbl_ctrl_t          tctrl;
    logic [EAW-1:0]     edge_waddr;
    logic [NB-1:0]      edge_wdata;
    logic [EAW-1:0]     edge_raddr;
    logic [NB-1:0]      edge_rdata;
    logic [NB-1:0]      info_raddr;
    logic [NB-1:0]      info_rfail;
    node_attr_t         info_rattr;

    logic [SW-1:0]            end_ext;
    logic [SW-1:0]            len_ext;
    logic [SW-1:0]            start_full;
    logic [DEPTH_W-1:0]       word_len;
    logic [POSITION_BITS-1:0] pos_inc;

    // Unpack the input word
    assign cmd       = cmd_t'(s_tuser);
    assign in_node   = s_tdata[S_NODE_LSB +: FNODE_W];
    assign in_byte   = s_tdata[S_BYTE_LSB +: BYTE_W];
    assign in_target = s_tdata[S_TARGET_LSB +: FNODE_W];
    assign in_attr   = '{depth:   s_tdata[S_DEPTH_LSB +: DEPTH_W],
                         is_word: s_tdata[S_WORD_LSB],
                         kind:    s_tdata[S_KIND_LSB +: KIND_W]};
    assign node_ok   = 32'(in_node) < 32'(NODE_COUNT);
    assign node_idx  = NB'(in_node);
    assign tgt_clean = (32'(in_target) < 32'(NODE_COUNT)) ? NB'(in_target) : '0;

    // Handshake: only a pending match can need the output register
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && (out_free || !pend_valid_reg);
    assign accept   = s_tvalid && s_tready;

    // Start of the pending match, floored at zero
    assign end_ext    = SW'(pend_end_reg) + SW'(1);
    assign len_ext    = SW'(pend_len_reg);
    assign start_full = (len_ext > end_ext) ? '0 : end_ext - len_ext;

    // Match length from the word node, capped
    assign word_len = (8'(info_rattr.depth) > 8'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH)
                                                            : info_rattr.depth;

    // Saturating text position
    assign pos_inc = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;

    acs_tables #(
        .NODE_COUNT (NODE_COUNT)
    ) u_tables (
        .clk        (clk),
        .ctrl       (tctrl),
        .edge_waddr (edge_waddr),
        .edge_wdata (edge_wdata),
        .edge_raddr (edge_raddr),
        .edge_rdata (edge_rdata),
        .info_waddr (node_idx),
        .info_wfail (tgt_clean),
        .info_wattr (in_attr),
        .info_raddr (info_raddr),
        .info_rfail (info_rfail),
        .info_rattr (info_rattr)
    );

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            cur_reg        <= '0;
            try_reg        <= '0;
            emitted_reg    <= 1'b0;
            pos_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_end_reg   <= '0;
            pend_len_reg   <= '0;
            pend_kind_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            cur_reg        <= cur_next;
            try_reg        <= try_next;
            emitted_reg    <= emitted_next;
            pos_reg        <= pos_next;
            pend_valid_reg <= pend_valid_next;
            pend_end_reg   <= pend_end_next;
            pend_len_reg   <= pend_len_next;
            pend_kind_reg  <= pend_kind_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        byte_reg      <= byte_next;
        out_start_reg <= out_start_next;
        out_len_reg   <= out_len_next;
        out_kind_reg  <= out_kind_next;
    end

    // Sequencer: next state, table strobes and match bookkeeping
    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        cur_next        = cur_reg;
        byte_next       = byte_reg;
        try_next        = try_reg;
        emitted_next    = emitted_reg;
        pos_next        = pos_reg;
        pend_valid_next = pend_valid_reg;
        pend_end_next   = pend_end_reg;
        pend_len_next   = pend_len_reg;
        pend_kind_next  = pend_kind_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_start_next  = out_start_reg;
        out_len_next    = out_len_reg;
        out_kind_next   = out_kind_reg;
        tctrl           = '0;
        edge_waddr      = {node_idx, in_byte};
        edge_wdata      = tgt_clean;
        edge_raddr      = {cur_reg, in_byte};
        info_raddr      = cur_reg;

        unique case (state_reg)
            // Sweep the edge memory to zero after reset
            ST_CLEAR:
            begin
                tctrl.edge_we = 1'b1;
                edge_waddr    = clr_addr_reg;
                edge_wdata    = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == EAW'(EDGE_LAST))
                begin
                    state_next = ST_IDLE;
                end
            end

            // Take a word and decode its command
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd)
                        CMD_LOAD_EDGE:
                        begin
                            tctrl.edge_we = node_ok;
                        end
                        CMD_LOAD_NODE:
                        begin
                            tctrl.info_we = node_ok;
                        end
                        CMD_SCAN:
                        begin
                            tctrl.edge_re = 1'b1;
                            byte_next     = in_byte;
                            try_next      = 2'd1;
                            emitted_next  = 1'b0;
                            state_next    = ST_EDGE;
                        end
                        CMD_END:
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_start_next = start_full[START_W-1:0];
                                out_len_next   = pend_len_reg;
                                out_kind_next  = pend_kind_reg;
                            end
                            cur_next        = '0;
                            pos_next        = '0;
                            pend_valid_next = 1'b0;
                            pend_end_next   = '0;
                            pend_len_next   = '0;
                            pend_kind_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Edge lookup result: advance to the child or fall back
            ST_EDGE:
            begin
                if (edge_rdata != '0)
                begin
                    cur_next      = edge_rdata;
                    info_raddr    = edge_rdata;
                    tctrl.info_re = 1'b1;
                    state_next    = ST_WORD;
                end
                else if (try_reg == 2'd1)
                begin
                    if (pend_valid_reg)
                    begin
                        // Emit the pending match, hold while the output is full
                        if (out_free)
                        begin
                            out_valid_next  = 1'b1;
                            out_start_next  = start_full[START_W-1:0];
                            out_len_next    = pend_len_reg;
                            out_kind_next   = pend_kind_reg;
                            pend_valid_next = 1'b0;
                            emitted_next    = 1'b1;
                            tctrl.info_re   = 1'b1;
                            state_next      = ST_FAIL;
                        end
                    end
                    else
                    begin
                        tctrl.info_re = 1'b1;
                        state_next    = ST_FAIL;
                    end
                end
                else if (try_reg == 2'd2 && emitted_reg)
                begin
                    tctrl.info_re = 1'b1;
                    state_next    = ST_FAIL;
                end
                else
                begin
                    pos_next   = pos_inc;
                    state_next = ST_IDLE;
                end
            end

            // Follow the fail link and retry the byte
            ST_FAIL:
            begin
                cur_next      = info_rfail;
                edge_raddr    = {info_rfail, byte_reg};
                tctrl.edge_re = 1'b1;
                try_next      = try_reg + 2'd1;
                state_next    = ST_EDGE;
            end

            // Child attributes: record the match if it ends a word
            ST_WORD:
            begin
                if (info_rattr.is_word)
                begin
                    pend_valid_next = 1'b1;
                    pend_end_next   = pos_reg;
                    pend_len_next   = word_len;
                    pend_kind_next  = info_rattr.kind;
                end
                pos_next   = pos_inc;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output word
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - M_USED_W)'(0), out_kind_reg, out_len_reg, out_start_reg};

endmodule

// ===== sv/acs_checker.sv =====
// Port-level checks for the Aho-Corasick longest-match scanner, bound to
// the top level. Uses acs_pkg for command codes and output field positions.
module acs_checker
    import acs_pkg::*;
#(
    parameter int MAX_DEPTH = 63
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [CMD_W-1:0]     s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // Hold a stalled output word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

    // Drop ready for the cycle after a scan byte is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == CMD_SCAN |=> !s_tready)
    else $error("scan byte did not occupy the sequencer");

    // Loads never create a match
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid
        && (s_tuser == CMD_LOAD_EDGE || s_tuser == CMD_LOAD_NODE) |=> !m_tvalid)
    else $error("load word produced an output word");

    // Reported length stays within the depth cap
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> 8'(m_tdata[M_LEN_LSB +: DEPTH_W]) <= 8'(MAX_DEPTH))
    else $error("match length above cap");

endmodule

bind aho_corasick_longest_match_scanner acs_checker #(
    .MAX_DEPTH (MAX_DEPTH)
) u_acs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
